>>> hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the postfix expression evaluator: symbol
// codes, status codes, operator codes and the divider request/response.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int WordWidth = 32;

   // expression symbols
   localparam logic [7:0] SYM_END  = 8'h00;
   localparam logic [7:0] SYM_ADD  = 8'h2B;
   localparam logic [7:0] SYM_SUB  = 8'h2D;
   localparam logic [7:0] SYM_MUL  = 8'h2A;
   localparam logic [7:0] SYM_DIV  = 8'h2F;
   localparam logic [7:0] SYM_REM  = 8'h25;
   localparam logic [7:0] SYM_ZERO = 8'h30;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNDER   = 3'd1;
   localparam logic [2:0] ST_OVER    = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] dividend;
      logic [WordWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [WordWidth-1:0] quotient;
      logic [WordWidth-1:0] remainder;
   } div_rsp_type;

endpackage

>>> hw/rtl/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider
// Iterative signed divider: restoring division on magnitudes, one quotient
// bit per cycle, results truncated toward zero. Done pulses once all 32 quotient bits are formed.
// ----------------------------------------------------------------------------
module rpn_divider
   import rpn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int StepBits = $clog2(WordWidth);

   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] quo_ff, quo_in;
   logic [WordWidth-1:0] dvs_ff, dvs_in;
   logic [StepBits-1:0]  step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_q_ff, neg_q_in;
   logic                 neg_r_ff, neg_r_in;

   logic [WordWidth:0]   shifted;
   logic [WordWidth:0]   trial;

   assign shifted = {rem_ff, quo_ff[WordWidth-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (div_req.start) begin
         // load magnitudes and remember the result signs
         rem_in   = '0;
         quo_in   = div_req.dividend[WordWidth-1] ? -div_req.dividend : div_req.dividend;
         dvs_in   = div_req.divisor[WordWidth-1] ? -div_req.divisor : div_req.divisor;
         step_in  = '0;
         busy_in  = 1'b1;
         neg_q_in = div_req.dividend[WordWidth-1] ^ div_req.divisor[WordWidth-1];
         neg_r_in = div_req.dividend[WordWidth-1];
      end else if (busy_ff) begin
         if (!trial[WordWidth]) begin
            rem_in = trial[WordWidth-1:0];
            quo_in = {quo_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[WordWidth-1:0];
            quo_in = {quo_ff[WordWidth-2:0], 1'b0};
         end
         step_in = step_ff + StepBits'(1);
         if (step_ff == StepBits'(WordWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      step_ff  <= step_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign div_rsp = '{done:      done_ff,
                      quotient:  neg_q_ff ? -quo_ff : quo_ff,
                      remainder: neg_r_ff ? -rem_ff : rem_ff};

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_step_runs_to_end: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && step_ff != StepBits'(WordWidth - 1)) |=> busy_ff)
      else $error("divider stopped early");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");
`endif

endmodule

>>> hw/rtl/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Digits and the end symbol are done in the accepting transfer; + - * go via
// S_EXEC; / and % go on to S_DIV and wait for the bit-serial divider.
// Input stalls until the current symbol is done and while a result is stalled.
// Reset empties the stack and clears the sticky error; stack RAM is not cleared.
// Top of stack lives in a register, lower entries in a one-write, one-read RAM.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = 128
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   localparam int AddrWidth  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CountWidth = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [2:0]             err_ff, err_in;
   logic [WordWidth-1:0]   top_ff, top_in;
   logic [WordWidth-1:0]   rd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0]   rsp_value_ff, rsp_value_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   logic [WordWidth-1:0]   stack_mem [STACK_DEPTH];
   logic                   wr_en;
   logic [CountWidth-1:0]  count_m1;
   logic [CountWidth-1:0]  count_m2;
   logic [AddrWidth-1:0]   wr_addr;
   logic [AddrWidth-1:0]   rd_addr;

   logic                   accept;
   logic                   is_op;
   logic [WordWidth-1:0]   push_word;
   logic [WordWidth-1:0]   mul_res;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_op     = req_symbol inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_REM};
   assign push_word = WordWidth'(req_symbol) - WordWidth'(SYM_ZERO);
   assign mul_res   = rd_ff * top_ff;

   assign count_m1 = count_ff - CountWidth'(1);
   assign count_m2 = count_ff - CountWidth'(2);
   assign wr_addr  = count_m1[AddrWidth-1:0];
   assign rd_addr  = count_m2[AddrWidth-1:0];

   assign div_req = '{start:    (state_ff == S_EXEC) && (op_ff inside {OP_DIV, OP_REM}),
                      dividend: rd_ff,
                      divisor:  top_ff};

   rpn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      wr_en         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_symbol == SYM_END) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = (count_ff != '0) ? top_ff : '0;
                  if (err_ff != ST_OK) begin
                     rsp_status_in = err_ff;
                  end else if (count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_status_in = ST_OK;
                  end
                  count_in = '0;
                  err_in   = ST_OK;
               end else if (is_op) begin
                  if (count_ff < CountWidth'(2)) begin
                     if (err_ff == ST_OK) err_in = ST_UNDER;
                  end else if ((req_symbol inside {SYM_DIV, SYM_REM}) && (top_ff == '0)) begin
                     if (err_ff == ST_OK) err_in = ST_DIVZERO;
                  end else begin
                     case (req_symbol)
                        SYM_ADD: op_in = OP_ADD;
                        SYM_SUB: op_in = OP_SUB;
                        SYM_MUL: op_in = OP_MUL;
                        SYM_DIV: op_in = OP_DIV;
                        default: op_in = OP_REM;
                     endcase
                     // left operand is read from RAM during this transfer
                     state_in = S_EXEC;
                  end
               end else begin
                  if (count_ff >= CountWidth'(STACK_DEPTH)) begin
                     if (err_ff == ST_OK) err_in = ST_OVER;
                  end else begin
                     // spill the old top into RAM
                     wr_en    = (count_ff != '0);
                     top_in   = push_word;
                     count_in = count_ff + CountWidth'(1);
                  end
               end
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_ADD: begin
                  top_in   = rd_ff + top_ff;
                  count_in = count_m1;
                  state_in = S_IDLE;
               end
               OP_SUB: begin
                  top_in   = rd_ff - top_ff;
                  count_in = count_m1;
                  state_in = S_IDLE;
               end
               OP_MUL: begin
                  top_in   = mul_res;
                  count_in = count_m1;
                  state_in = S_IDLE;
               end
               default: state_in = S_DIV;
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               top_in   = (op_ff == OP_REM) ? div_rsp.remainder : div_rsp.quotient;
               count_in = count_m1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(STACK_DEPTH))
      else $error("stack count beyond depth");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider result outside divide state");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_symbol == SYM_END) |=> (count_ff == '0 && err_ff == ST_OK && rsp_valid_ff))
      else $error("end symbol did not clear the evaluator");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_symbol == SYM_END))
      else $error("result raised without an end symbol");
   a_exec_has_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (count_ff >= CountWidth'(2)))
      else $error("operator executing with fewer than two words");
`endif

endmodule
